// File: rtl/iff_pkg.sv
// integer field formatter package: port widths, conversion kind codes,
// ascii constants and the digit-to-character helper
// no dependencies
package iff_pkg;

  localparam int MAX_WIDTH_DEF = 64;
  localparam int ARG_W         = 64;
  localparam int DEC_DIGITS    = 20;
  localparam int HEX_DIGITS    = 16;
  localparam int DIG_W         = 4 * DEC_DIGITS;
  localparam int NDIG_W        = $clog2(DEC_DIGITS + 1);
  localparam int FW_W          = 7;
  localparam int S_TDATA_W     = 72;
  localparam int S_TUSER_W     = 5;
  localparam int CH_W          = 8;

  localparam logic [2:0] CMD_CHAR = 3'd0;
  localparam logic [2:0] CMD_SDEC = 3'd1;
  localparam logic [2:0] CMD_UDEC = 3'd2;
  localparam logic [2:0] CMD_HEX  = 3'd3;
  localparam logic [2:0] CMD_PTR  = 3'd4;

  localparam logic [7:0] ASC_SPACE = 8'h20;
  localparam logic [7:0] ASC_MINUS = 8'h2d;
  localparam logic [7:0] ASC_ZERO  = 8'h30;
  localparam logic [7:0] ASC_X     = 8'h78;
  localparam logic [7:0] ASC_A     = 8'h61;

  function automatic logic [7:0] digit_ascii(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = ASC_ZERO + {4'b0, d};
    end else begin
      r = ASC_A + {4'b0, d} - 8'd10;
    end
    return r;
  endfunction

endpackage

// File: rtl/integer_field_formatter.sv
// integer field formatter top level: bit-serial binary to decimal,
// leading-zero strip and one character per transaction out
// depends on iff_pkg
//
// channel | dir | tdata                                  | tuser            | tlast
// s_*     | in  | arg_value, field_width, zero_pad       | cmd, long_count  | -
// m_*     | out | ch                                     | -                | last
//
// decimal: accept, a shift-and-adjust loop over the argument, strip shifts of leading zero
// digits and a count step, then one character per cycle unless m_tready stalls the output;
// hex and pointer skip the conversion; character kind: a strip step, then output
// the shift-and-adjust loop sets the decimal latency, the output width the rest
// synchronous active-high reset clears the state machine and the output valid
// a stall on m_tready holds the character register and the output sequence
module integer_field_formatter #(
  parameter int MAX_WIDTH = iff_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [iff_pkg::S_TDATA_W-1:0]  s_tdata,  // arg_value[63:0], field_width[70:64], zero_pad[71]
  input  logic [iff_pkg::S_TUSER_W-1:0]  s_tuser,  // cmd[2:0], long_count[4:3]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [iff_pkg::CH_W-1:0]       m_tdata,  // ch[7:0]
  output logic                           m_tlast
);
  import iff_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CONV  = 4'b0010,
    S_STRIP = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [ARG_W-1:0]  sv;
  logic [DIG_W-1:0]  dig;
  logic [DIG_W-1:0]  dab;
  logic [5:0]        bit_cnt;
  logic [NDIG_W-1:0] ndig;
  logic [15:0]       pre;
  logic [1:0]        pre_cnt;
  logic [7:0]        pad_char;
  logic [CW-1:0]     wid;
  logic [CW-1:0]     tot_cnt;
  logic [CW-1:0]     pad_cnt;

  logic [ARG_W-1:0]  arg;
  logic [FW_W-1:0]   fw;
  logic              zp;
  logic [2:0]        cmd;
  logic [1:0]        lc;
  logic              lc0;
  logic [ARG_W-1:0]  cut;
  logic [ARG_W-1:0]  ext;
  logic              neg;
  logic [ARG_W-1:0]  mag;
  logic [CW-1:0]     fw_sat;

  logic              take;
  logic              strip_shift;
  logic [CW-1:0]     len_w;
  logic              load_out;
  logic [7:0]        ch_next;

  assign arg = s_tdata[63:0];
  assign fw  = s_tdata[70:64];
  assign zp  = s_tdata[71];
  assign cmd = s_tuser[2:0];
  assign lc  = s_tuser[4:3];

  assign s_tready = (state == S_IDLE);
  assign take     = s_tvalid && s_tready;

  // argument cut, sign extension and magnitude
  always_comb begin
    lc0    = (lc == 2'd0);
    cut    = (cmd != CMD_PTR && lc0) ? {32'b0, arg[31:0]} : arg;
    ext    = (cmd == CMD_SDEC && lc0) ? {{32{arg[31]}}, arg[31:0]} : cut;
    neg    = (cmd == CMD_SDEC) && ext[ARG_W-1];
    mag    = neg ? (ARG_W'(0) - ext) : ext;
    fw_sat = (fw > FW_W'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(fw);
  end

  // add-3 correction on every bcd digit
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      dab[4*i +: 4] = (dig[4*i +: 4] >= 4'd5) ? dig[4*i +: 4] + 4'd3 : dig[4*i +: 4];
    end
  end

  assign strip_shift = (ndig > NDIG_W'(1)) && (dig[DIG_W-1 -: 4] == 4'd0);
  assign len_w       = CW'(ndig) + CW'(pre_cnt);
  assign load_out    = (state == S_OUT) && (!m_tvalid || m_tready);

  always_comb begin
    if (pad_cnt != '0) begin
      ch_next = pad_char;
    end else if (pre_cnt != 2'd0) begin
      ch_next = pre[15:8];
    end else begin
      ch_next = digit_ascii(dig[DIG_W-1 -: 4]);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take) begin
          case (cmd)
            CMD_CHAR, CMD_HEX, CMD_PTR: state_next = S_STRIP;
            CMD_SDEC, CMD_UDEC:         state_next = S_CONV;
            default:                    state_next = S_IDLE;
          endcase
        end
      end
      S_CONV: begin
        if (bit_cnt == 6'd63) begin
          state_next = S_STRIP;
        end
      end
      S_STRIP: begin
        if (!strip_shift) begin
          state_next = (wid == '0 && len_w == '0) ? S_IDLE : S_OUT;
        end
      end
      S_OUT: begin
        if (load_out && tot_cnt == CW'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (take) begin
          pad_char <= zp ? ASC_ZERO : ASC_SPACE;
          wid      <= fw_sat;
          bit_cnt  <= 6'd0;
          case (cmd)
            CMD_CHAR: begin
              ndig    <= '0;
              pre     <= {arg[7:0], 8'h00};
              pre_cnt <= {1'b0, (arg[7:0] != 8'h00)};
            end
            CMD_SDEC, CMD_UDEC: begin
              sv      <= mag;
              dig     <= '0;
              ndig    <= NDIG_W'(DEC_DIGITS);
              pre     <= {ASC_MINUS, 8'h00};
              pre_cnt <= {1'b0, neg};
            end
            CMD_HEX: begin
              dig     <= {cut, 16'h0000};
              ndig    <= NDIG_W'(HEX_DIGITS);
              pre_cnt <= 2'd0;
            end
            CMD_PTR: begin
              dig     <= {arg, 16'h0000};
              ndig    <= NDIG_W'(HEX_DIGITS);
              pre     <= {ASC_ZERO, ASC_X};
              pre_cnt <= 2'd2;
            end
            default: ;
          endcase
        end
      end
      S_CONV: begin
        dig     <= {dab[DIG_W-2:0], sv[ARG_W-1]};
        sv      <= {sv[ARG_W-2:0], 1'b0};
        bit_cnt <= bit_cnt + 6'd1;
      end
      S_STRIP: begin
        if (strip_shift) begin
          dig  <= {dig[DIG_W-5:0], 4'h0};
          ndig <= ndig - NDIG_W'(1);
        end else if (wid > len_w) begin
          pad_cnt <= wid - len_w;
          tot_cnt <= wid;
        end else begin
          pad_cnt <= '0;
          tot_cnt <= len_w;
        end
      end
      S_OUT: begin
        if (load_out) begin
          m_tdata <= ch_next;
          m_tlast <= (tot_cnt == CW'(1));
          tot_cnt <= tot_cnt - CW'(1);
          if (pad_cnt != '0) begin
            pad_cnt <= pad_cnt - CW'(1);
          end else if (pre_cnt != 2'd0) begin
            pre     <= {pre[7:0], 8'h00};
            pre_cnt <= pre_cnt - 2'd1;
          end else begin
            dig  <= {dig[DIG_W-5:0], 4'h0};
            ndig <= ndig - NDIG_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // a non-final character in the output register means more are coming
  a_nonlast_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> state == S_OUT)
    else $error("non-final character pending outside output phase");

  a_out_counts: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> (tot_cnt != '0) && (pad_cnt <= tot_cnt))
    else $error("output counters inconsistent");

  a_conv_end: assert property (@(posedge clk) disable iff (rst)
    state == S_CONV && bit_cnt == 6'd63 |=> state == S_STRIP)
    else $error("conversion did not end after 64 bits");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    load_out && tot_cnt == CW'(1) |=> m_tvalid && m_tlast && state == S_IDLE)
    else $error("final character not marked");

endmodule

// File: tb/tb.sv
// testbench for integer_field_formatter: random and directed conversion requests,
// each character checked against an in-bench formatter model
// depends on iff_pkg and rtl/integer_field_formatter.sv
module tb;
  import iff_pkg::*;

  localparam logic [2:0] CMD_RSVD_LO = 3'd5;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;
  localparam int N_RANDOM = 430;
  localparam int HOLD_CYCLES = 600;
  localparam int HOLD_AT = 150;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  lmod;
    logic [63:0] arg;
    logic [6:0]  fw;
    logic        zpad;
  } conv_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;  // arg_value[63:0], field_width[70:64], zero_pad[71]
  logic [S_TUSER_W-1:0] s_tuser = '0;  // cmd[2:0], long_count[4:3]
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [CH_W-1:0] m_tdata;  // ch[7:0]
  logic m_tlast;

  conv_t pending_reqs[$];
  char_t expected_chars[$];
  conv_t cur_req;
  int n_acc = 0;
  int n_chars = 0;
  int errors = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  integer_field_formatter u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle phases: none, sender idle, receiver stall, both
  function automatic int send_idle_pct();
    case ((n_acc / 64) % 4)
      1: return 48;
      3: return 24;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case ((n_acc / 64) % 4)
      2: return 48;
      3: return 24;
      default: return 0;
    endcase
  endfunction

  function automatic void format_conversion(input conv_t c);
    logic [7:0] text [0:23];
    logic [7:0] rev [0:19];
    logic [63:0] v;
    logic [63:0] q;
    logic [7:0] pad;
    logic [3:0] d;
    bit started;
    int len;
    int n;
    int width;
    int npad;
    int total;
    char_t r;
    len = 0;
    n = 0;
    started = 1'b0;
    v = c.arg;
    width = (c.fw > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(c.fw);
    pad = c.zpad ? ASC_ZERO : ASC_SPACE;
    if (c.kind > CMD_PTR) return;
    if (c.kind != CMD_PTR && c.lmod == 2'd0) v[63:32] = '0;
    case (c.kind)
      CMD_CHAR: begin
        if (v[7:0] != 8'd0) begin
          text[0] = v[7:0];
          len = 1;
        end
      end
      CMD_SDEC, CMD_UDEC: begin
        if (c.kind == CMD_SDEC) begin
          if (c.lmod == 2'd0 && v[31]) v[63:32] = '1;
          if (v[63]) begin
            text[0] = ASC_MINUS;
            len = 1;
            v = 64'd0 - v;
          end
        end
        do begin
          q = v % 64'd10;
          rev[n] = ASC_ZERO + q[7:0];
          n++;
          v = v / 64'd10;
        end while (v != 64'd0);
        for (int i = 0; i < n; i++) text[len + i] = rev[n - 1 - i];
        len += n;
      end
      default: begin
        if (c.kind == CMD_PTR) begin
          text[0] = ASC_ZERO;
          text[1] = ASC_X;
          len = 2;
        end
        for (int pos = 60; pos >= 0; pos -= 4) begin
          d = v[pos +: 4];
          if (d != 4'd0 || started || pos == 0) begin
            started = 1'b1;
            text[len] = (d < 4'd10) ? ASC_ZERO + {4'b0, d} : ASC_A + {4'b0, d} - 8'd10;
            len++;
          end
        end
      end
    endcase
    npad = (width > len) ? width - len : 0;
    total = npad + len;
    for (int k = 0; k < total; k++) begin
      r.ch = (k < npad) ? pad : text[k - npad];
      r.last = (k == total - 1);
      expected_chars.push_back(r);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        format_conversion(cur_req);
        n_acc <= n_acc + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
          cur_req = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {cur_req.zpad, cur_req.fw, cur_req.arg};
          s_tuser <= {cur_req.lmod, cur_req.kind};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off to back up the input side
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (!hold_done && n_acc >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct());
    end
  end

  // monitor
  always @(posedge clk) begin
    char_t e;
    if (!rst && m_tvalid && m_tready) begin
      n_chars++;
      if (expected_chars.size() == 0) begin
        if (errors < 10) $display("unexpected character %h last %b", m_tdata, m_tlast);
        errors++;
      end else begin
        e = expected_chars.pop_front();
        if (m_tdata !== e.ch || m_tlast !== e.last) begin
          if (errors < 10) begin
            $display("mismatch at char %0d: expected ch %h last %b, got ch %h last %b",
                     n_chars, e.ch, e.last, m_tdata, m_tlast);
          end
          errors++;
        end
      end
    end
  end

  task automatic add_req(input logic [2:0] kind, input logic [1:0] lmod,
                         input logic [63:0] arg, input logic [6:0] fw, input logic zpad);
    conv_t c;
    c.kind = kind;
    c.lmod = lmod;
    c.arg = arg;
    c.fw = fw;
    c.zpad = zpad;
    pending_reqs.push_back(c);
  endtask

  function automatic logic [63:0] rand_arg();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return v;
      1: return 64'($urandom_range(999));
      2: return '1;
      3: return 64'd1 << $urandom_range(63);
      4: return 64'd0 - 64'($urandom_range(999));
      default: return {v[63:32], ($urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff)};
    endcase
  endfunction

  function automatic logic [6:0] rand_width();
    int p;
    p = $urandom_range(99);
    if (p < 70) return 7'($urandom_range(24));
    if (p < 90) return 7'($urandom_range(64, 25));
    return 7'($urandom_range(127, 65));
  endfunction

  initial begin
    logic [2:0] kind;
    logic [63:0] arg;
    // directed: field extremes and corner cases
    add_req(CMD_CHAR, 2'd0, 64'h41, 7'd0, 1'b0);
    add_req(CMD_CHAR, 2'd0, 64'h0, 7'd0, 1'b0);
    add_req(CMD_CHAR, 2'd0, 64'h100, 7'd5, 1'b1);
    add_req(CMD_CHAR, 2'd1, 64'hffff_ffff_ffff_ff7e, 7'd3, 1'b0);
    add_req(CMD_CHAR, 2'd3, 64'h1234_5641, 7'd127, 1'b1);
    add_req(CMD_SDEC, 2'd0, 64'h0, 7'd0, 1'b0);
    add_req(CMD_SDEC, 2'd0, 64'hffff_ffff, 7'd4, 1'b1);
    add_req(CMD_SDEC, 2'd0, 64'h1234_5678_8000_0000, 7'd0, 1'b0);
    add_req(CMD_SDEC, 2'd1, 64'h8000_0000_0000_0000, 7'd0, 1'b0);
    add_req(CMD_SDEC, 2'd2, 64'h7fff_ffff_ffff_ffff, 7'd64, 1'b1);
    add_req(CMD_SDEC, 2'd3, 64'hffff_ffff_ffff_fffb, 7'd10, 1'b1);
    add_req(CMD_UDEC, 2'd1, '1, 7'd64, 1'b1);
    add_req(CMD_UDEC, 2'd0, '1, 7'd127, 1'b0);
    add_req(CMD_UDEC, 2'd0, 64'hffff_ffff_0000_0007, 7'd64, 1'b0);
    add_req(CMD_UDEC, 2'd2, 64'd10_000_000_000_000_000_000, 7'd20, 1'b0);
    add_req(CMD_HEX, 2'd0, 64'h0, 7'd0, 1'b0);
    add_req(CMD_HEX, 2'd3, '1, 7'd0, 1'b0);
    add_req(CMD_HEX, 2'd0, 64'hffff_0000_dead_beef, 7'd20, 1'b0);
    add_req(CMD_PTR, 2'd0, 64'h0, 7'd0, 1'b0);
    add_req(CMD_PTR, 2'd0, 64'hffff_0000_0000_0001, 7'd0, 1'b1);
    add_req(CMD_PTR, 2'd2, '1, 7'd64, 1'b1);
    add_req(CMD_PTR, 2'd1, 64'h0abc, 7'd65, 1'b0);
    for (int k = CMD_RSVD_LO; k <= CMD_RSVD_HI; k++) add_req(3'(k), 2'd1, '1, 7'd64, 1'b1);
    // random requests
    for (int i = 0; i < N_RANDOM; i++) begin
      kind = ($urandom_range(99) < 6) ? 3'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO))
                                     : 3'($urandom_range(CMD_PTR));
      arg = rand_arg();
      if (kind == CMD_CHAR && $urandom_range(3) == 0) arg[7:0] = 8'd0;
      add_req(kind, 2'($urandom_range(3)), arg, rand_width(), 1'($urandom_range(1)));
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() != 0 || s_tvalid || expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d requests over all kinds, widths and idle phases, %0d characters",
             n_acc, n_chars);
    $display("one long receiver hold-off of %0d cycles, %0d mismatches", HOLD_CYCLES, errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d characters still expected", expected_chars.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
